FILE: hw/rtl/mpss_pkg.sv
// Shared types and constants for the multi-pattern substring search block.
`default_nettype none

package mpss_pkg;

	localparam int NUM_PATTERNS    = 3;
	localparam int MAX_PATTERN_LEN = 8;
	localparam int MAX_TEXT        = 65536;
	localparam int WINDOW          = 7;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 4;
	localparam int LEN_IDX_W  = $clog2(MAX_PATTERN_LEN) > 0 ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam int COUNT_W    = 2;
	localparam int POS_W      = 16;
	localparam int CNT_W      = POS_W + 1;
	localparam int WORD_W     = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Bytes past this count are not compared and raise the overflow flag.
	localparam int TEXT_LIMIT = (MAX_TEXT > 65536) ? 65536 : MAX_TEXT;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_0       = 3'd0,
		CFG_PATTERN_1       = 3'd1,
		CFG_PATTERN_2       = 3'd2,
		CFG_LENGTH_0        = 3'd3,
		CFG_LENGTH_1        = 3'd4,
		CFG_LENGTH_2        = 3'd5,
		CFG_PATTERN_COUNT   = 3'd6,
		CFG_SEARCH_FROM_END = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              last;
	} in_word_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             overflow;
	} out_word_t;

	typedef struct packed {
		logic [NUM_PATTERNS-1:0][WORD_W-1:0] pattern_word;
		logic [NUM_PATTERNS-1:0][LEN_W-1:0]  length;
		logic [COUNT_W-1:0]                  pattern_count;
		logic                                search_from_end;
	} cfg_t;

	typedef struct packed {
		logic [NUM_PATTERNS-1:0]            hit;
		logic [NUM_PATTERNS-1:0][POS_W-1:0] start;
	} match_t;

endpackage

`default_nettype wire

FILE: hw/rtl/multi_pattern_substring_search.sv
// Top level of the multi-pattern substring search: handshakes, text state and result folding.
// A word marked last is accepted into the input register, folded when it leaves that
// register, and its result is then presented from the output register.
// Throughput: one text word per cycle; a word marked last waits in the input register
// only while the previous result is still held in the output register.
// Reset: arst_n clears the text state, empties both registers and sets pattern_count to 1;
// pattern words, lengths and the search direction reset to zero.
`default_nettype none

module multi_pattern_substring_search
	import mpss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers. Writes are always taken.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q               <= '0;
			cfg_q.pattern_count <= COUNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PATTERN_0:       cfg_q.pattern_word[0] <= cfg_data[WORD_W-1:0];
				CFG_PATTERN_1:       cfg_q.pattern_word[1] <= cfg_data[WORD_W-1:0];
				CFG_PATTERN_2:       cfg_q.pattern_word[2] <= cfg_data[WORD_W-1:0];
				CFG_LENGTH_0:        cfg_q.length[0]       <= cfg_data[LEN_W-1:0];
				CFG_LENGTH_1:        cfg_q.length[1]       <= cfg_data[LEN_W-1:0];
				CFG_LENGTH_2:        cfg_q.length[2]       <= cfg_data[LEN_W-1:0];
				CFG_PATTERN_COUNT:   cfg_q.pattern_count   <= cfg_data[COUNT_W-1:0];
				CFG_SEARCH_FROM_END: cfg_q.search_from_end <= cfg_data[0];
			endcase
		end
	end

	// Output register.
	logic      out_valid_q;
	out_word_t out_data_q;

	// Input register. The word in it is folded in the cycle it leaves; a word
	// marked last may only leave when the output register has room.
	logic     valid_s1;
	in_word_t in_s1;
	logic     out_free;
	logic     fire_s1;

	assign out_free = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && (!in_s1.last || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	// Running text state.
	logic [WINDOW-1:0][BYTE_W-1:0] recent_q;
	logic [CNT_W-1:0]              byte_pos_q;
	logic [POS_W-1:0]              best_q;
	logic                          have_q;
	logic                          ended_q;
	logic                          ovf_q;

	match_t match;

	mpss_match u_match (
		.cfg       (cfg_q),
		.text_byte (in_s1.text_byte),
		.recent    (recent_q),
		.position  (byte_pos_q[POS_W-1:0]),
		.match     (match)
	);

	logic             zero_byte;
	logic             at_limit;
	logic             take;
	logic             any_empty;
	logic             have_f;
	logic [POS_W-1:0] best_f;
	logic             ovf_f;

	assign zero_byte = (in_s1.text_byte == '0);
	assign at_limit  = (byte_pos_q >= CNT_W'(TEXT_LIMIT));
	assign take      = !ended_q && !zero_byte && !at_limit;
	assign ovf_f     = ovf_q || (!ended_q && !zero_byte && at_limit);

	always_comb begin
		any_empty = 1'b0;
		for (int j = 0; j < NUM_PATTERNS; j++) begin
			if ((COUNT_W'(j) < cfg_q.pattern_count) && (cfg_q.length[j] == '0)) begin
				any_empty = 1'b1;
			end
		end
	end

	// Fold every start found at this byte into the best start so far: the
	// smallest start searching forward, the greatest searching from the end.
	always_comb begin
		have_f = have_q;
		best_f = best_q;
		if (take) begin
			for (int j = 0; j < NUM_PATTERNS; j++) begin
				if (match.hit[j]) begin
					if (!have_f) begin
						best_f = match.start[j];
						have_f = 1'b1;
					end else if (cfg_q.search_from_end) begin
						if (match.start[j] > best_f) begin
							best_f = match.start[j];
						end
					end else if (match.start[j] < best_f) begin
						best_f = match.start[j];
					end
				end
			end
		end
		// An empty pattern counts as a match at the start of the text. Only a
		// forward search, or a search with nothing found yet, takes it.
		if (in_s1.last && any_empty) begin
			if (!have_f || !cfg_q.search_from_end) begin
				best_f = '0;
			end
			have_f = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q   <= '0;
			byte_pos_q <= '0;
			best_q     <= '0;
			have_q     <= 1'b0;
			ended_q    <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (fire_s1) begin
			if (in_s1.last) begin
				recent_q   <= '0;
				byte_pos_q <= '0;
				best_q     <= '0;
				have_q     <= 1'b0;
				ended_q    <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				if (take) begin
					recent_q   <= {recent_q[WINDOW-2:0], in_s1.text_byte};
					byte_pos_q <= byte_pos_q + CNT_W'(1);
				end
				best_q  <= best_f;
				have_q  <= have_f;
				ended_q <= ended_q || zero_byte;
				ovf_q   <= ovf_f;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && in_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && in_s1.last) begin
			out_data_q.found    <= have_f;
			out_data_q.position <= have_f ? best_f : '0;
			out_data_q.overflow <= ovf_f;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The text state starts over after every result.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && in_s1.last |=> byte_pos_q == '0 && !have_q && !ended_q && !ovf_q)
		else $error("text state not cleared after a last word");

	// A result appears only when a last word has just been folded.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire_s1 && in_s1.last))
		else $error("result appeared without a last word");

	// The byte counter never runs past the text limit.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= CNT_W'(TEXT_LIMIT))
		else $error("byte position past the text limit");

	// A result with nothing found reports position zero.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.found |-> out_data_q.position == '0)
		else $error("nonzero position without a match");

endmodule

`default_nettype wire

FILE: hw/rtl/mpss_match.sv
// Window comparator: tests every pattern against the bytes ending at the current byte.
`default_nettype none

module mpss_match
	import mpss_pkg::*;
(
	input  cfg_t                          cfg,
	input  logic [BYTE_W-1:0]             text_byte,
	input  logic [WINDOW-1:0][BYTE_W-1:0] recent,
	input  logic [POS_W-1:0]              position,
	output match_t                        match
);

	logic [WINDOW:0][BYTE_W-1:0]                     win;
	logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0]    eq;
	logic [NUM_PATTERNS-1:0][LEN_W-1:0]              len_m1;
	logic [NUM_PATTERNS-1:0][LEN_IDX_W-1:0]          len_idx;
	logic [NUM_PATTERNS-1:0]                         active;
	logic [NUM_PATTERNS-1:0]                         in_range;
	logic [NUM_PATTERNS-1:0]                         reach;

	always_comb begin
		win[0] = text_byte;
		for (int i = 1; i <= WINDOW; i++) begin
			win[i] = recent[i-1];
		end
	end

	// For each candidate length l+1, byte k of the pattern lines up with the
	// byte that arrived l-k items ago. All alignments are fixed taps.
	always_comb begin
		for (int j = 0; j < NUM_PATTERNS; j++) begin
			for (int l = 0; l < MAX_PATTERN_LEN; l++) begin
				eq[j][l] = 1'b1;
				for (int k = 0; k <= l; k++) begin
					eq[j][l] = eq[j][l] &&
						(cfg.pattern_word[j][k*BYTE_W +: BYTE_W] == win[l-k]);
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_PATTERNS; j++) begin
			len_m1[j]   = cfg.length[j] - LEN_W'(1);
			len_idx[j]  = len_m1[j][LEN_IDX_W-1:0];
			active[j]   = COUNT_W'(j) < cfg.pattern_count;
			in_range[j] = (cfg.length[j] != '0) &&
				(cfg.length[j] <= LEN_W'(MAX_PATTERN_LEN));
			reach[j]    = ({1'b0, position} + CNT_W'(1)) >= CNT_W'(cfg.length[j]);
			match.hit[j]   = active[j] && in_range[j] && reach[j] && eq[j][len_idx[j]];
			match.start[j] = position + POS_W'(1) - POS_W'(cfg.length[j]);
		end
	end

endmodule

`default_nettype wire
